// File: hdl/rbb_pkg.sv
// ----------------------------------------------------------------------------
// rbb_pkg: shared types and constants of the row box blur
// Holds the pixel layout, the register map, the controller states and the
// command and status groups exchanged between controller and datapath.
// ----------------------------------------------------------------------------
package rbb_pkg;

   localparam int MAX_RADIUS_DEF = 8;

   localparam int PIX_W  = 24;
   localparam int CH_W   = 8;
   localparam int NUM_CH = 3;

   // Width of the radius field in the register.
   localparam int CFG_W = 4;

   // Row position counter saturates at its top value.
   localparam int          POS_W   = 5;
   localparam logic [4:0]  POS_MAX = 5'd31;

   // Window bound arithmetic; wide enough for every radius up to sixteen.
   localparam int CALC_W = 7;

   localparam int APB_DATA_W  = 32;
   localparam int APB_ADDR_W  = 3;
   localparam int REG_IDX_LSB = 2;

   localparam logic REG_BLUR_RADIUS = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SETUP,
      ST_SUM,
      ST_DRAIN,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic wr;
      logic clear;
      logic rd;
      logic div_step;
      logic load;
      logic row_end;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic out_free;
   } sts_type;

endpackage

// File: hdl/rbb_ctrl.sv
// ----------------------------------------------------------------------------
// rbb_ctrl: row box blur controller
// Tracks the row position and the results still owed, works out the window
// bounds and divisor of each result, and sequences the datapath.
// ----------------------------------------------------------------------------
module rbb_ctrl #(
   parameter int MAX_RADIUS = rbb_pkg::MAX_RADIUS_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   input  logic                                       req_row_end,
   output logic                                       req_ready,
   input  logic                                       cfg_clear,
   input  logic [$clog2(MAX_RADIUS+1)-1:0]            radius,
   input  rbb_pkg::sts_type                           sts,
   output rbb_pkg::cmd_type                           cmd,
   output logic [$clog2(2*MAX_RADIUS+1)-1:0]          rd_age,
   output logic [$clog2(2*MAX_RADIUS+2)-1:0]          divisor
);

   localparam int WIN_DEPTH = 2 * MAX_RADIUS + 1;
   localparam int AGE_W     = $clog2(WIN_DEPTH);
   localparam int RAD_W     = $clog2(MAX_RADIUS + 1);
   localparam int PEND_W    = $clog2(MAX_RADIUS + 2);
   localparam int CNT_W     = $clog2(WIN_DEPTH + 1);
   localparam int CALC_W    = rbb_pkg::CALC_W;

   rbb_pkg::state_type              state_ff, state_in;
   logic [rbb_pkg::POS_W-1:0]       row_pos_ff, row_pos_in;
   logic [PEND_W-1:0]               pend_ff, pend_in;
   logic                            last_ff, last_in;
   logic [RAD_W-1:0]                center_ff, center_in;
   logic [AGE_W-1:0]                tap_ff, tap_in;
   logic [AGE_W-1:0]                hi_ff, hi_in;
   logic [CNT_W-1:0]                cnt_ff, cnt_in;

   logic [CALC_W-1:0]               lo_w, hi_sum, pos_top, hi_a, hi_w, cnt_w;
   logic                            emit;

   always_comb begin
      lo_w    = (CALC_W'(center_ff) > CALC_W'(radius)) ?
                CALC_W'(center_ff) - CALC_W'(radius) : '0;
      hi_sum  = CALC_W'(center_ff) + CALC_W'(radius);
      pos_top = CALC_W'(row_pos_ff) - CALC_W'(1);
      hi_a    = (hi_sum > pos_top) ? pos_top : hi_sum;
      hi_w    = (hi_a > CALC_W'(WIN_DEPTH - 1)) ? CALC_W'(WIN_DEPTH - 1) : hi_a;
      cnt_w   = hi_w - lo_w + CALC_W'(1);
      emit    = (CALC_W'(pend_ff) > CALC_W'(radius)) || (last_ff && (pend_ff != '0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= rbb_pkg::ST_IDLE;
         row_pos_ff <= '0;
         pend_ff    <= '0;
         last_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         row_pos_ff <= row_pos_in;
         pend_ff    <= pend_in;
         last_ff    <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      center_ff <= center_in;
      tap_ff    <= tap_in;
      hi_ff     <= hi_in;
      cnt_ff    <= cnt_in;
   end

   always_comb begin
      state_in   = state_ff;
      row_pos_in = row_pos_ff;
      pend_in    = pend_ff;
      last_in    = last_ff;
      center_in  = center_ff;
      tap_in     = tap_ff;
      hi_in      = hi_ff;
      cnt_in     = cnt_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      unique case (state_ff)
         rbb_pkg::ST_IDLE: begin
            req_ready = !cfg_clear;
            if (cfg_clear) begin
               row_pos_in = '0;
               pend_in    = '0;
            end else if (req_valid) begin
               cmd.wr     = 1'b1;
               row_pos_in = (row_pos_ff == rbb_pkg::POS_MAX) ?
                            row_pos_ff : row_pos_ff + 1'b1;
               pend_in    = pend_ff + 1'b1;
               last_in    = req_row_end;
               state_in   = rbb_pkg::ST_DECIDE;
            end
         end
         rbb_pkg::ST_DECIDE: begin
            if (emit) begin
               center_in = RAD_W'(pend_ff - PEND_W'(1));
               state_in  = rbb_pkg::ST_SETUP;
            end else begin
               if (last_ff) begin
                  row_pos_in = '0;
               end
               state_in = rbb_pkg::ST_IDLE;
            end
         end
         rbb_pkg::ST_SETUP: begin
            cmd.clear = 1'b1;
            tap_in    = AGE_W'(lo_w);
            hi_in     = AGE_W'(hi_w);
            cnt_in    = CNT_W'(cnt_w);
            state_in  = rbb_pkg::ST_SUM;
         end
         rbb_pkg::ST_SUM: begin
            cmd.rd = 1'b1;
            if (tap_ff == hi_ff) begin
               state_in = rbb_pkg::ST_DRAIN;
            end else begin
               tap_in = tap_ff + 1'b1;
            end
         end
         rbb_pkg::ST_DRAIN: begin
            state_in = rbb_pkg::ST_DIV;
         end
         rbb_pkg::ST_DIV: begin
            if (sts.div_done) begin
               state_in = rbb_pkg::ST_OUT;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         rbb_pkg::ST_OUT: begin
            if (sts.out_free) begin
               cmd.load    = 1'b1;
               cmd.row_end = last_ff && (center_ff == '0);
               pend_in     = pend_ff - 1'b1;
               state_in    = rbb_pkg::ST_DECIDE;
            end
         end
         default: begin
            state_in = rbb_pkg::ST_IDLE;
         end
      endcase
   end

   assign rd_age  = tap_ff;
   assign divisor = cnt_ff;

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rbb_pkg::ST_IDLE) |-> (CALC_W'(pend_ff) <= CALC_W'(radius)))
      else $error("owed results exceed the radius while idle");

   a_divisor_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rbb_pkg::ST_DIV) |->
         ((cnt_ff != '0) && (CALC_W'(cnt_ff) <= CALC_W'(WIN_DEPTH))))
      else $error("divisor outside the window size");

endmodule

// File: hdl/rbb_dp.sv
// ----------------------------------------------------------------------------
// rbb_dp: row box blur datapath
// Window memory, per-channel tap accumulators that turn into a bit-serial
// restoring divider, and the result register.
// ----------------------------------------------------------------------------
module rbb_dp #(
   parameter int MAX_RADIUS = rbb_pkg::MAX_RADIUS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  rbb_pkg::cmd_type                      cmd,
   output rbb_pkg::sts_type                      sts,
   input  logic [$clog2(2*MAX_RADIUS+1)-1:0]     rd_age,
   input  logic [$clog2(2*MAX_RADIUS+2)-1:0]     divisor,
   input  logic [rbb_pkg::PIX_W-1:0]             wr_pixel,
   output logic [rbb_pkg::PIX_W-1:0]             out_pixel,
   output logic                                  out_row_end,
   output logic                                  out_valid,
   input  logic                                  out_ready
);

   localparam int WIN_DEPTH = 2 * MAX_RADIUS + 1;
   localparam int AGE_W     = $clog2(WIN_DEPTH);
   localparam int CNT_W     = $clog2(WIN_DEPTH + 1);
   localparam int CH_W      = rbb_pkg::CH_W;
   localparam int NUM_CH    = rbb_pkg::NUM_CH;
   localparam int PIX_W     = rbb_pkg::PIX_W;
   localparam int SUM_W     = CH_W + $clog2(WIN_DEPTH);
   localparam int STEP_W    = $clog2(SUM_W + 1);

   logic [PIX_W-1:0]   win_mem [WIN_DEPTH];
   logic [AGE_W-1:0]   newest_ff, newest_in, wr_addr, rd_addr;
   logic [PIX_W-1:0]   rd_data_ff;
   logic               rd_valid_ff;

   logic [SUM_W-1:0]   num_ff [NUM_CH];
   logic [SUM_W-1:0]   num_in [NUM_CH];
   logic [CNT_W-1:0]   rem_ff [NUM_CH];
   logic [CNT_W-1:0]   rem_in [NUM_CH];
   logic [CNT_W:0]     shifted [NUM_CH];
   logic [CNT_W:0]     diff [NUM_CH];
   logic               ge [NUM_CH];
   logic [STEP_W-1:0]  step_ff, step_in;

   logic [PIX_W-1:0]   out_pix_ff, out_pix_in;
   logic               out_end_ff;
   logic               out_valid_ff, out_valid_in;

   always_comb begin
      wr_addr   = (newest_ff == AGE_W'(WIN_DEPTH - 1)) ? '0 : newest_ff + 1'b1;
      newest_in = cmd.wr ? wr_addr : newest_ff;
      if (newest_ff >= rd_age) begin
         rd_addr = newest_ff - rd_age;
      end else begin
         rd_addr = AGE_W'((AGE_W+1)'(newest_ff) + (AGE_W+1)'(WIN_DEPTH)
                          - (AGE_W+1)'(rd_age));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         win_mem[wr_addr] <= wr_pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rd_data_ff <= win_mem[rd_addr];
      end
   end

   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         shifted[ch] = {rem_ff[ch], num_ff[ch][SUM_W-1]};
         diff[ch]    = shifted[ch] - {1'b0, divisor};
         ge[ch]      = shifted[ch] >= {1'b0, divisor};
         num_in[ch]  = num_ff[ch];
         rem_in[ch]  = rem_ff[ch];
         if (cmd.clear) begin
            num_in[ch] = '0;
            rem_in[ch] = '0;
         end else if (rd_valid_ff) begin
            num_in[ch] = num_ff[ch]
                       + SUM_W'(rd_data_ff[PIX_W-1-ch*CH_W -: CH_W]);
         end else if (cmd.div_step) begin
            rem_in[ch] = ge[ch] ? diff[ch][CNT_W-1:0] : shifted[ch][CNT_W-1:0];
            num_in[ch] = {num_ff[ch][SUM_W-2:0], ge[ch]};
         end
      end
      if (cmd.clear) begin
         step_in = '0;
      end else if (cmd.div_step) begin
         step_in = step_ff + 1'b1;
      end else begin
         step_in = step_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         num_ff[ch] <= num_in[ch];
         rem_ff[ch] <= rem_in[ch];
      end
   end

   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         out_pix_in[PIX_W-1-ch*CH_W -: CH_W] = num_ff[ch][CH_W-1:0];
      end
      if (cmd.load) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         newest_ff    <= '0;
         rd_valid_ff  <= 1'b0;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         newest_ff    <= newest_in;
         rd_valid_ff  <= cmd.rd;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         out_pix_ff <= out_pix_in;
         out_end_ff <= cmd.row_end;
      end
   end

   assign sts.div_done = (step_ff == STEP_W'(SUM_W));
   assign sts.out_free = !out_valid_ff || out_ready;
   assign out_pixel    = out_pix_ff;
   assign out_row_end  = out_end_ff;
   assign out_valid    = out_valid_ff;

   a_load_after_div: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> sts.div_done)
      else $error("result loaded before the division finished");

   a_quotient_fits: assert property (@(posedge clock) disable iff (reset)
      sts.div_done |-> ((num_ff[0][SUM_W-1:CH_W] == '0)
                     && (num_ff[1][SUM_W-1:CH_W] == '0)
                     && (num_ff[2][SUM_W-1:CH_W] == '0)))
      else $error("channel mean does not fit in a channel");

endmodule

// File: hdl/row_box_blur.sv
// ----------------------------------------------------------------------------
// row_box_blur: horizontal box blur over a row-wise RGB pixel stream
// Gives the truncated per-channel mean over a window cut at the row edges.
//
//   channel   role    handshake             payload
//   req       input   req_valid/req_ready   req_pixel_in, req_row_end_in
//   rsp       output  rsp_valid/rsp_ready   rsp_pixel_out, rsp_row_end_out
//   csr       config  APB psel/penable      blur_radius at byte address 0
//
// One input beat is taken at a time; each result is paced by the one-tap-a-cycle
// window read and by the bit-serial divider, which forms SUM_W quotient bits
// (SUM_W is 13 at the default radius).
// A row's last beat gives all of its owed results in turn.
// Reset is synchronous and needs no clearing pass.
// A stalled rsp beat holds the block once the next result is ready.
// ----------------------------------------------------------------------------
module row_box_blur #(
   parameter int MAX_RADIUS = rbb_pkg::MAX_RADIUS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [rbb_pkg::PIX_W-1:0]         req_pixel_in,
   input  logic                              req_row_end_in,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [rbb_pkg::PIX_W-1:0]         rsp_pixel_out,
   output logic                              rsp_row_end_out,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [rbb_pkg::APB_ADDR_W-1:0]    paddr,
   input  logic [rbb_pkg::APB_DATA_W-1:0]    pwdata,
   output logic [rbb_pkg::APB_DATA_W-1:0]    prdata,
   output logic                              pready
);

   localparam int RAD_W = $clog2(MAX_RADIUS + 1);
   localparam int CFG_W = rbb_pkg::CFG_W;

   logic [RAD_W-1:0]                        radius_ff, radius_in;
   logic [CFG_W:0]                          wr_val;
   logic                                    sel_radius, cfg_clear;
   rbb_pkg::cmd_type                        cmd;
   rbb_pkg::sts_type                        sts;
   logic [$clog2(2*MAX_RADIUS+1)-1:0]       rd_age;
   logic [$clog2(2*MAX_RADIUS+2)-1:0]       divisor;

   assign sel_radius = (paddr[rbb_pkg::REG_IDX_LSB] == rbb_pkg::REG_BLUR_RADIUS);
   assign cfg_clear  = psel && penable && pwrite && pready && sel_radius;
   assign wr_val     = {1'b0, pwdata[CFG_W-1:0]};

   always_comb begin
      radius_in = radius_ff;
      if (cfg_clear) begin
         radius_in = (wr_val > (CFG_W+1)'(MAX_RADIUS)) ?
                     RAD_W'(MAX_RADIUS) : RAD_W'(wr_val);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= '0;
      end else begin
         radius_ff <= radius_in;
      end
   end

   assign pready = 1'b1;
   assign prdata = sel_radius ? rbb_pkg::APB_DATA_W'(radius_ff) : '0;

   rbb_ctrl #(
      .MAX_RADIUS (MAX_RADIUS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_row_end (req_row_end_in),
      .req_ready   (req_ready),
      .cfg_clear   (cfg_clear),
      .radius      (radius_ff),
      .sts         (sts),
      .cmd         (cmd),
      .rd_age      (rd_age),
      .divisor     (divisor)
   );

   rbb_dp #(
      .MAX_RADIUS (MAX_RADIUS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .rd_age      (rd_age),
      .divisor     (divisor),
      .wr_pixel    (req_pixel_in),
      .out_pixel   (rsp_pixel_out),
      .out_row_end (rsp_row_end_out),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready)
   );

endmodule
